>>> rtl/pgc_pkg.sv
package pgc_pkg;

  localparam int FIELD_WIDTH = 32;

  // genotype packing codes
  localparam logic [1:0] MODE_8BIT = 2'd0;
  localparam logic [1:0] MODE_4BIT = 2'd1;
  localparam logic [1:0] MODE_2BIT = 2'd2;

  typedef struct packed {
    logic [7:0] byte_a;
    logic [7:0] byte_b;
    logic [2:0] valid_slots;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [FIELD_WIDTH-1:0] concordant_count;
    logic [FIELD_WIDTH-1:0] comparison_count;
  } out_t;

  // per-byte increments, 0 to 4 each
  typedef struct packed {
    logic [2:0] conc;
    logic [2:0] comp;
  } slot_inc_t;

endpackage

>>> rtl/pgc_slot_compare.sv
module pgc_slot_compare (
  input  logic [1:0]        width_mode,
  input  pgc_pkg::in_t      item,
  output pgc_pkg::slot_inc_t inc
);

  logic [3:0] slot_en;
  logic [3:0] slot_comp;
  logic [3:0] slot_conc;
  logic [2:0] vs;

  assign vs = item.valid_slots;

  always_comb begin
    slot_en   = '0;
    slot_comp = '0;
    slot_conc = '0;
    case (width_mode)
      pgc_pkg::MODE_4BIT: begin
        for (int s = 0; s < 2; s++) begin
          slot_en[s]   = (vs > 3'(s));
          slot_comp[s] = (|item.byte_a[7-4*s -: 4]) && (|item.byte_b[7-4*s -: 4]);
          slot_conc[s] = slot_comp[s] && (item.byte_a[7-4*s -: 4] == item.byte_b[7-4*s -: 4]);
        end
      end
      pgc_pkg::MODE_2BIT: begin
        for (int s = 0; s < 4; s++) begin
          slot_en[s]   = (vs > 3'(s));
          slot_comp[s] = (|item.byte_a[7-2*s -: 2]) && (|item.byte_b[7-2*s -: 2]);
          slot_conc[s] = slot_comp[s] && (item.byte_a[7-2*s -: 2] == item.byte_b[7-2*s -: 2]);
        end
      end
      default: begin
        // eight-bit packing, also the unused code
        slot_en[0]   = (vs != 3'd0);
        slot_comp[0] = (|item.byte_a) && (|item.byte_b);
        slot_conc[0] = slot_comp[0] && (item.byte_a == item.byte_b);
      end
    endcase
  end

  assign inc.comp = 3'($countones(slot_en & slot_comp));
  assign inc.conc = 3'($countones(slot_en & slot_conc));

endmodule

>>> rtl/pgc_accum.sv
module pgc_accum #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               stage_valid,
  input  logic               stage_last,
  input  pgc_pkg::slot_inc_t inc,
  output logic               take,
  output logic               out_valid,
  output pgc_pkg::out_t      out_data,
  input  logic               out_stall
);

  localparam int SUM_W = COUNT_WIDTH + 1;

  logic [COUNT_WIDTH-1:0] conc_total;
  logic [COUNT_WIDTH-1:0] comp_total;
  logic [SUM_W-1:0]       conc_sum;
  logic [SUM_W-1:0]       comp_sum;
  logic [COUNT_WIDTH-1:0] conc_next;
  logic [COUNT_WIDTH-1:0] comp_next;
  logic [pgc_pkg::FIELD_WIDTH-1:0] conc_field;
  logic [pgc_pkg::FIELD_WIDTH-1:0] comp_field;
  logic out_free;

  // saturate: max is all ones, so a carry out means clip
  assign conc_sum  = {1'b0, conc_total} + SUM_W'(inc.conc);
  assign comp_sum  = {1'b0, comp_total} + SUM_W'(inc.comp);
  assign conc_next = conc_sum[COUNT_WIDTH] ? '1 : conc_sum[COUNT_WIDTH-1:0];
  assign comp_next = comp_sum[COUNT_WIDTH] ? '1 : comp_sum[COUNT_WIDTH-1:0];

  generate
    if (COUNT_WIDTH > pgc_pkg::FIELD_WIDTH) begin : g_clip
      assign conc_field = (|conc_next[COUNT_WIDTH-1:pgc_pkg::FIELD_WIDTH]) ?
                          '1 : conc_next[pgc_pkg::FIELD_WIDTH-1:0];
      assign comp_field = (|comp_next[COUNT_WIDTH-1:pgc_pkg::FIELD_WIDTH]) ?
                          '1 : comp_next[pgc_pkg::FIELD_WIDTH-1:0];
    end else begin : g_ext
      assign conc_field = pgc_pkg::FIELD_WIDTH'(conc_next);
      assign comp_field = pgc_pkg::FIELD_WIDTH'(comp_next);
    end
  endgenerate

  assign out_free = !out_valid || !out_stall;
  // only a last byte needs the result register
  assign take     = stage_valid && (!stage_last || out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      conc_total <= '0;
      comp_total <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (take && stage_last) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (take) begin
        if (stage_last) begin
          conc_total <= '0;
          comp_total <= '0;
        end else begin
          conc_total <= conc_next;
          comp_total <= comp_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && stage_last) begin
      out_data.concordant_count <= conc_field;
      out_data.comparison_count <= comp_field;
    end
  end

endmodule

>>> rtl/packed_genotype_concordance.sv
// Genotype concordance counter over two packed genotype streams. Each request
// carries one byte of each array; width_mode selects 8, 4 or 2 bits per
// genotype (1, 2 or 4 slots, high bits first) and valid_slots trims the tail
// byte. Slots where both codes are nonzero add to the comparison count, equal
// ones also to the concordant count; both saturate. The byte marked last_byte
// is counted, then both totals go out as one result and restart from zero.
// One request is taken every cycle; only a last byte waits on a full result
// register, others keep flowing. Path: input register, slot compare, then the
// accumulators and result register, loaded as the last byte leaves the input
// register. Write width_mode only while no stream is in progress.
module packed_genotype_concordance #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  pgc_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output pgc_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_data
);

  logic               stage_valid;
  pgc_pkg::in_t       stage;
  logic [1:0]         width_mode;
  logic               take;
  logic               accept;
  pgc_pkg::slot_inc_t inc;

  assign cfg_ready = 1'b1;
  assign in_stall  = stage_valid && !take;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_mode  <= pgc_pkg::MODE_8BIT;
      stage_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        width_mode <= cfg_data;
      end
      if (accept) begin
        stage_valid <= 1'b1;
      end else if (take) begin
        stage_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage <= in_data;
    end
  end

  pgc_slot_compare u_compare (
    .width_mode (width_mode),
    .item       (stage),
    .inc        (inc)
  );

  pgc_accum #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_accum (
    .clk         (clk),
    .rst         (rst),
    .stage_valid (stage_valid),
    .stage_last  (stage.last_byte),
    .inc         (inc),
    .take        (take),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .out_stall   (out_stall)
  );

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    take && stage.last_byte |=> out_valid)
    else $error("last byte taken without result");

  a_conc_le_comp: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.concordant_count <= out_data.comparison_count)
    else $error("concordant count above comparison count");

  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty result register");

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int COUNT_W = 32;
  localparam int SETTLE = 6;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  pgc_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  pgc_pkg::out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_data = pgc_pkg::MODE_8BIT;

  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;

  // predictor state
  logic [1:0] mode_shadow = pgc_pkg::MODE_8BIT;
  logic [63:0] conc_total = '0;
  logic [63:0] comp_total = '0;
  pgc_pkg::out_t totals_q[$];

  packed_genotype_concordance #(
    .COUNT_WIDTH(COUNT_W)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 100) begin
      $display("MISMATCH at %0t: %s", $time, msg);
    end
    mismatch_count++;
  endtask

  // bits per genotype; the unused code falls back to eight
  function automatic int unsigned slot_bits(input logic [1:0] mode);
    case (mode)
      pgc_pkg::MODE_4BIT: return 4;
      pgc_pkg::MODE_2BIT: return 2;
      default: return 8;
    endcase
  endfunction

  task automatic tally_byte(input pgc_pkg::in_t item);
    int unsigned bits, slots, n, sh, ga, gb, msk;
    logic [63:0] cap;
    pgc_pkg::out_t res;
    cap = (64'd1 << COUNT_W) - 64'd1;
    bits = slot_bits(mode_shadow);
    slots = 8 / bits;
    msk = (1 << bits) - 1;
    n = (item.valid_slots > slots) ? slots : item.valid_slots;
    for (int s = 0; s < n; s++) begin
      sh = 8 - bits * (s + 1);
      ga = (item.byte_a >> sh) & msk;
      gb = (item.byte_b >> sh) & msk;
      if (ga != 0 && gb != 0) begin
        if (ga == gb && conc_total < cap) conc_total++;
        if (comp_total < cap) comp_total++;
      end
    end
    if (item.last_byte) begin
      res.concordant_count = (conc_total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : conc_total[31:0];
      res.comparison_count = (comp_total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : comp_total[31:0];
      totals_q.push_back(res);
      conc_total = '0;
      comp_total = '0;
    end
  endtask

  // in_valid stays high on return so back-to-back requests need no re-raise
  task automatic send_genotypes(input pgc_pkg::in_t item);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tally_byte(item);
  endtask

  task automatic send_pair(input logic [7:0] a, input logic [7:0] b,
                           input logic [2:0] slots, input logic last);
    pgc_pkg::in_t item;
    item.byte_a = a;
    item.byte_b = b;
    item.valid_slots = slots;
    item.last_byte = last;
    send_genotypes(item);
  endtask

  task automatic drain_results(input int unsigned settle);
    in_valid <= 1'b0;
    do @(posedge clk); while (totals_q.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_mode(input logic [1:0] mode);
    drain_results(SETTLE);
    cfg_valid <= 1'b1;
    cfg_data <= mode;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    mode_shadow = mode;
  endtask

  // mostly real genotype pairs with plenty of matches and missing codes
  function automatic pgc_pkg::in_t random_pair();
    pgc_pkg::in_t p;
    int unsigned bits, top, ga, gb, acc_a, acc_b;
    bits = slot_bits(mode_shadow);
    top = (1 << bits) - 1;
    acc_a = 0;
    acc_b = 0;
    for (int s = 0; s < 8 / bits; s++) begin
      ga = $urandom_range(top);
      case ($urandom_range(9))
        0, 1, 2, 3: gb = ga;
        4: gb = 0;
        default: gb = $urandom_range(top);
      endcase
      if ($urandom_range(9) == 0) ga = 0;
      acc_a = (acc_a << bits) | ga;
      acc_b = (acc_b << bits) | gb;
    end
    p.byte_a = acc_a[7:0];
    p.byte_b = acc_b[7:0];
    if ($urandom_range(9) == 0) begin
      p.byte_a = 8'($urandom_range(255));
      p.byte_b = 8'($urandom_range(255));
    end
    p.valid_slots = 3'(8 / bits);
    p.last_byte = 1'b0;
    return p;
  endfunction

  task automatic send_stream(input int unsigned len);
    pgc_pkg::in_t item;
    for (int i = 0; i < len; i++) begin
      item = random_pair();
      if (i == len - 1) begin
        item.valid_slots = 3'($urandom_range(7));
        item.last_byte = 1'b1;
      end else if ($urandom_range(9) == 0) begin
        item.valid_slots = 3'($urandom_range(7));
      end
      send_genotypes(item);
    end
  endtask

  task automatic test_eight_bit_mode();
    write_mode(pgc_pkg::MODE_8BIT);
    send_pair(8'hFF, 8'hFF, 3'd1, 1'b0);
    send_pair(8'h00, 8'hFF, 3'd1, 1'b0);
    send_pair(8'hFF, 8'h00, 3'd1, 1'b0);
    send_pair(8'h01, 8'h80, 3'd7, 1'b0);  // slot count beyond one slot
    send_pair(8'h5A, 8'h5A, 3'd0, 1'b1);  // no slot counts
  endtask

  task automatic test_four_bit_mode();
    write_mode(pgc_pkg::MODE_4BIT);
    send_pair(8'hF1, 8'hF1, 3'd2, 1'b0);
    send_pair(8'h0F, 8'hFF, 3'd2, 1'b0);
    send_pair(8'hE2, 8'hE3, 3'd5, 1'b0);
    send_pair(8'h77, 8'h70, 3'd1, 1'b1);  // tail byte, high slot only
  endtask

  task automatic test_two_bit_mode();
    write_mode(pgc_pkg::MODE_2BIT);
    send_pair(8'hE4, 8'hE4, 3'd4, 1'b0);
    send_pair(8'h1B, 8'hE4, 3'd4, 1'b0);
    send_pair(8'hFF, 8'h55, 3'd3, 1'b0);
    send_pair(8'hAA, 8'hAB, 3'd6, 1'b1);
    send_pair(8'h00, 8'h00, 3'd4, 1'b1);  // all missing, single-byte stream
  endtask

  task automatic test_unused_mode();
    write_mode(MODE_UNUSED);
    send_pair(8'h12, 8'h12, 3'd4, 1'b1);
    send_pair(8'h00, 8'h34, 3'd1, 1'b1);
    send_pair(8'hC3, 8'hC3, 3'd0, 1'b1);
  endtask

  task automatic test_long_streams();
    write_mode(pgc_pkg::MODE_2BIT);
    // half the bytes concordant, half compared but discordant
    for (int i = 0; i < 66; i++) begin
      if (i % 2 == 0) send_pair(8'hFF, 8'hFF, 3'd4, 1'b0);
      else send_pair(8'h55, 8'hAA, 3'd4, i == 65);
    end
    for (int i = 0; i < 70; i++) begin
      send_pair(8'hFF, 8'hFF, 3'd4, i == 69);
    end
  endtask

  task automatic test_random_traffic(input int unsigned src_pct, input int unsigned sink_pct,
                                     input int unsigned n_items);
    logic [1:0] mode_seq[4];
    int unsigned sent, len, pick;
    mode_seq = '{pgc_pkg::MODE_8BIT, pgc_pkg::MODE_4BIT, pgc_pkg::MODE_2BIT, MODE_UNUSED};
    src_idle_pct = src_pct;
    sink_stall_pct = sink_pct;
    for (int m = 0; m < 4; m++) begin
      write_mode(mode_seq[m]);
      sent = 0;
      while (sent < n_items / 4) begin
        pick = $urandom_range(99);
        if (pick < 80) len = $urandom_range(1, 8);
        else if (pick < 95) len = $urandom_range(9, 40);
        else len = $urandom_range(41, 100);
        send_stream(len);
        sent += len;
        // occasionally hold off until every total is back
        if ($urandom_range(19) == 0) drain_results(0);
      end
    end
  endtask

  always @(posedge clk) begin
    pgc_pkg::out_t want;
    out_stall <= ($urandom_range(99) < sink_stall_pct);
    if (!rst && out_valid && !out_stall) begin
      if (totals_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d/%0d",
                                  out_data.concordant_count, out_data.comparison_count));
      end else begin
        want = totals_q.pop_front();
        if (out_data.concordant_count !== want.concordant_count) begin
          report_mismatch($sformatf("concordant_count %0d, want %0d",
                                    out_data.concordant_count, want.concordant_count));
        end
        if (out_data.comparison_count !== want.comparison_count) begin
          report_mismatch($sformatf("comparison_count %0d, want %0d",
                                    out_data.comparison_count, want.comparison_count));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    src_idle_pct = 16;
    sink_stall_pct = 71;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_eight_bit_mode();
    test_four_bit_mode();
    test_two_bit_mode();
    test_unused_mode();
    test_long_streams();
    test_random_traffic(16, 71, 580);
    test_random_traffic(71, 16, 580);
    test_random_traffic(0, 0, 580);
    drain_results(SETTLE);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/pgc_pkg.sv
rtl/pgc_slot_compare.sv
rtl/pgc_accum.sv
rtl/packed_genotype_concordance.sv
test/tb_top.sv
